// ===== rtl/lcd_controller_serial_writer_assert.svh =====
// Assertion macros shared by the serial writer checker.
// No dependencies; included by files that assert.
`ifndef LCD_CONTROLLER_SERIAL_WRITER_ASSERT_SVH
`define LCD_CONTROLLER_SERIAL_WRITER_ASSERT_SVH

// Clocked check, off while reset is asserted.
`define LCDSW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define LCDSW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/lcdsw_pkg.sv =====
// Shared types, constants and helpers for the serial writer.
// No dependencies.
`default_nettype none

package lcdsw_pkg;

  localparam int FRAME_W = 17;
  localparam int CNT_W   = $clog2(FRAME_W + 1);

  localparam int CMD_BITS   = 12;
  localparam int START_BITS = 17;
  localparam int CONT_BITS  = 8;

  localparam logic [2:0] ID_CMD   = 3'b100;
  localparam logic [2:0] ID_WRITE = 3'b101;

  typedef enum logic [1:0] {
    OP_CMD   = 2'd0,
    OP_START = 2'd1,
    OP_CONT  = 2'd2
  } opcode_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SEND = 1'b1
  } state_e;

  // Command from the sequencer to the shift unit.
  typedef struct packed {
    logic               load;
    logic               step;
    logic [FRAME_W-1:0] word;
    logic [CNT_W-1:0]   cnt;
  } sh_cmd_t;

  // Status back from the shift unit.
  typedef struct packed {
    logic sbit;
    logic last;
  } sh_sts_t;

  typedef struct packed {
    logic frame_start;
    logic frame_end;
  } flags_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lcdsw_shreg.sv =====
// Shift unit: holds the frame word and the count of bits left.
// Depends on lcdsw_pkg.
`default_nettype none

module lcdsw_shreg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lcdsw_pkg::sh_cmd_t cmd_i,
  output lcdsw_pkg::sh_sts_t     sts_o
);
  import lcdsw_pkg::*;

  logic [FRAME_W-1:0] word_q, word_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  always_comb begin
    word_d = word_q;
    cnt_d  = cnt_q;
    if (cmd_i.load) begin
      word_d = cmd_i.word;
      cnt_d  = cmd_i.cnt;
    end else if (cmd_i.step) begin
      word_d = {word_q[FRAME_W-2:0], 1'b0};
      cnt_d  = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  // Next bit out is always the MSB.
  assign sts_o.sbit = word_q[FRAME_W-1];
  assign sts_o.last = (cnt_q == CNT_W'(1));

endmodule

`default_nettype wire

// ===== rtl/lcdsw_seq.sv =====
// Sequencer: decodes an item, loads the shift unit, tracks the open frame.
// Depends on lcdsw_pkg.
`default_nettype none

module lcdsw_seq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_valid_i,
  output logic                    s_ready_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [7:0]         payload_i,
  input  wire logic [5:0]         addr_i,
  input  wire logic               close_i,
  output logic                    m_valid_o,
  input  wire logic               m_ready_i,
  output lcdsw_pkg::sh_cmd_t      sh_cmd_o,
  input  wire lcdsw_pkg::sh_sts_t sh_sts_i,
  output lcdsw_pkg::flags_t       flags_o
);
  import lcdsw_pkg::*;

  state_e state_q, state_d;
  logic   open_q, open_d;
  logic   start_q, start_d;
  logic   end_q, end_d;
  logic   is_start;

  always_comb begin
    state_d   = state_q;
    open_d    = open_q;
    start_d   = start_q;
    end_d     = end_q;
    s_ready_o = 1'b0;
    m_valid_o = 1'b0;
    sh_cmd_o  = '0;
    is_start  = (opcode_e'(opcode_i) == OP_START) || !open_q;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          unique case (opcode_e'(opcode_i))
            OP_CMD: begin
              sh_cmd_o.load = 1'b1;
              sh_cmd_o.word = {ID_CMD, payload_i, 1'b0, 5'b0};
              sh_cmd_o.cnt  = CNT_W'(CMD_BITS);
              start_d = 1'b1;
              end_d   = 1'b1;
              open_d  = 1'b0;
              state_d = ST_SEND;
            end
            OP_START, OP_CONT: begin
              sh_cmd_o.load = 1'b1;
              if (is_start) begin
                sh_cmd_o.word = {ID_WRITE, addr_i, rev8(payload_i)};
                sh_cmd_o.cnt  = CNT_W'(START_BITS);
              end else begin
                sh_cmd_o.word = {rev8(payload_i), 9'b0};
                sh_cmd_o.cnt  = CNT_W'(CONT_BITS);
              end
              start_d = is_start;
              end_d   = close_i;
              open_d  = !close_i;
              state_d = ST_SEND;
            end
            default: begin
              // undefined opcode: dropped, no beats
            end
          endcase
        end
      end
      ST_SEND: begin
        m_valid_o = 1'b1;
        if (m_ready_i) begin
          sh_cmd_o.step = 1'b1;
          start_d = 1'b0;
          if (sh_sts_i.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      open_q  <= 1'b0;
      start_q <= 1'b0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      open_q  <= open_d;
      start_q <= start_d;
      end_q   <= end_d;
    end
  end

  assign flags_o.frame_start = start_q;
  assign flags_o.frame_end   = end_q & sh_sts_i.last;

endmodule

`default_nettype wire

// ===== rtl/lcd_controller_serial_writer.sv =====
// Top level of the three-wire segment-LCD serial writer.
// Depends on lcdsw_pkg, lcdsw_seq and lcdsw_shreg.
//
//   channel | dir | tdata                      | tuser                  | tlast
//   s_axis  | in  | [7:0] payload [13:8] addr  | [1:0] opcode           | close_after
//   m_axis  | out | [0] serial_bit             | [0] start [1] end      | last bit of item
//
// Bits: an accepted item is loaded into the shift register, then sent one bit
//   per accepted m_axis beat: command 12, data start (or continue with no open
//   frame) 17, continue in an open frame 8; an undefined opcode sends nothing.
// The single shift register and its bit counter set these bit counts.
// s_axis_tready_o is high only while no item is in flight.
// A stall on m_axis just holds the current bit; reset closes any frame.
`default_nettype none

module lcd_controller_serial_writer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,  // [7:0] payload, [13:8] nibble_addr, [15:14] 0
  input  wire logic [1:0]  s_axis_tuser_i,  // [1:0] opcode
  input  wire logic        s_axis_tlast_i,  // close_after
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [0] serial_bit, [7:1] 0
  output logic [1:0]      m_axis_tuser_o,   // [0] frame_start, [1] frame_end
  output logic            m_axis_tlast_o    // last bit of this item
);
  import lcdsw_pkg::*;

  sh_cmd_t sh_cmd;
  sh_sts_t sh_sts;
  flags_t  flags;

  // Decode and frame tracking
  lcdsw_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .opcode_i  (s_axis_tuser_i),
    .payload_i (s_axis_tdata_i[7:0]),
    .addr_i    (s_axis_tdata_i[13:8]),
    .close_i   (s_axis_tlast_i),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .sh_cmd_o  (sh_cmd),
    .sh_sts_i  (sh_sts),
    .flags_o   (flags)
  );

  // Bit serializer, MSB of the loaded word goes out first
  lcdsw_shreg u_shreg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (sh_cmd),
    .sts_o  (sh_sts)
  );

  assign m_axis_tdata_o = {7'b0, sh_sts.sbit};
  assign m_axis_tuser_o = {flags.frame_end, flags.frame_start};
  assign m_axis_tlast_o = sh_sts.last;

endmodule

`default_nettype wire

// ===== rtl/lcdsw_checker.sv =====
// Port-level checks for the serial writer, bound to the top level.
// Depends on lcd_controller_serial_writer_assert.svh.
`default_nettype none
`include "lcd_controller_serial_writer_assert.svh"

module lcdsw_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid_i,
  input wire logic       s_axis_tready_o,
  input wire logic [15:0] s_axis_tdata_i,
  input wire logic [1:0]  s_axis_tuser_i,
  input wire logic        s_axis_tlast_i,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o,
  input wire logic [1:0] m_axis_tuser_o,
  input wire logic       m_axis_tlast_o
);

  // one item at a time: never taking input while a bit is offered
  `LCDSW_ASSERT(a_no_overlap, s_axis_tready_o |-> !m_axis_tvalid_o, "input ready while sending")

  // frame end only on an item's final bit
  `LCDSW_ASSERT(a_end_last, m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tlast_o, "early end")

  // pad bits stay zero
  `LCDSW_ASSERT(a_pad_zero, m_axis_tvalid_o |-> m_axis_tdata_o[7:1] == 7'd0, "tdata pad nonzero")

  // a stalled beat stays offered
  `LCDSW_ASSERT(a_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "valid dropped")

endmodule

bind lcd_controller_serial_writer lcdsw_checker u_lcdsw_checker (.*);

`default_nettype wire
